[hw/rtl/kcst_pkg.sv]
// Shared types, codes and defaults for the keyed counting semaphore table.
package kcst_pkg;

	localparam int unsigned TABLE_SLOTS_DEF = 64;
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	localparam int unsigned KEY_W       = 32;
	localparam int unsigned INIT_W      = 16;
	localparam int unsigned SLOT_W      = 6;
	localparam int unsigned COUNT_OUT_W = 16;

	typedef enum logic [1:0] {
		OP_OPEN = 2'd0,
		OP_WAIT = 2'd1,
		OP_POST = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NOT_FOUND   = 3'd1,
		ST_TABLE_FULL  = 3'd2,
		ST_WOULD_BLOCK = 3'd3,
		ST_SATURATED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [KEY_W-1:0] sem_key;
		logic [INIT_W-1:0]       init_value;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [SLOT_W-1:0]      slot;
		logic [COUNT_OUT_W-1:0] count_after;
		logic                   wake;
	} rsp_t;

	// Table write controls: new_en claims a slot (key, count, in-use bit),
	// count_en rewrites only the count of a slot in use.
	typedef struct packed {
		logic new_en;
		logic count_en;
	} tbl_wr_t;

endpackage

[hw/rtl/kcst_table.sv]
// Slot storage: in-use flags, key memory and count memory with a registered read port.
module kcst_table #(
	parameter int unsigned TABLE_SLOTS = kcst_pkg::TABLE_SLOTS_DEF,
	parameter int unsigned COUNT_WIDTH = kcst_pkg::COUNT_WIDTH_DEF,
	parameter int unsigned IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [IDX_W-1:0]             rd_addr,
	output logic [kcst_pkg::KEY_W-1:0]   rd_key_s1,
	output logic [COUNT_WIDTH-1:0]       rd_count_s1,
	output logic                         rd_used_s1,
	input  kcst_pkg::tbl_wr_t            wr,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [kcst_pkg::KEY_W-1:0]   wr_key,
	input  logic [COUNT_WIDTH-1:0]       wr_count
);
	import kcst_pkg::*;

	logic [TABLE_SLOTS-1:0] used_q;
	logic [KEY_W-1:0]       key_mem   [TABLE_SLOTS];
	logic [COUNT_WIDTH-1:0] count_mem [TABLE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			rd_used_s1 <= 1'b0;
		end else begin
			if (wr.new_en) begin
				used_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_used_s1 <= used_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.new_en) begin
			key_mem[wr_idx] <= wr_key;
		end
		if (wr.new_en || wr.count_en) begin
			count_mem[wr_idx] <= wr_count;
		end
		if (rd_en) begin
			rd_key_s1   <= key_mem[rd_addr];
			rd_count_s1 <= count_mem[rd_addr];
		end
	end

endmodule

[hw/rtl/kcst_alu.sv]
// Count update unit: decides status, new count and table write for one request.
module kcst_alu #(
	parameter int unsigned COUNT_WIDTH = kcst_pkg::COUNT_WIDTH_DEF,
	parameter int unsigned IDX_W       = 6
) (
	input  logic [1:0]                    op,
	input  logic                          found,
	input  logic [IDX_W-1:0]              match_idx,
	input  logic [COUNT_WIDTH-1:0]        cnt,
	input  logic                          free_found,
	input  logic [IDX_W-1:0]              free_idx,
	input  logic [kcst_pkg::INIT_W-1:0]   init_value,
	output kcst_pkg::rsp_t                rsp,
	output kcst_pkg::tbl_wr_t             wr,
	output logic [IDX_W-1:0]              wr_idx,
	output logic [COUNT_WIDTH-1:0]        wr_count
);
	import kcst_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] init_sat;

	// An initial count wider than the counter is clamped to its maximum.
	assign init_sat = ({16'd0, init_value} > 32'(CNT_MAX)) ? CNT_MAX
		: COUNT_WIDTH'(init_value);

	always_comb begin
		rsp.status      = ST_NOT_FOUND;
		rsp.slot        = '0;
		rsp.count_after = '0;
		rsp.wake        = 1'b0;
		wr              = '0;
		wr_idx          = match_idx;
		wr_count        = cnt;
		case (op)
			OP_OPEN: begin
				if (found) begin
					rsp.status      = ST_OK;
					rsp.slot        = SLOT_W'(match_idx);
					rsp.count_after = COUNT_OUT_W'(cnt);
				end else if (free_found) begin
					wr.new_en       = 1'b1;
					wr_idx          = free_idx;
					wr_count        = init_sat;
					rsp.status      = ST_OK;
					rsp.slot        = SLOT_W'(free_idx);
					rsp.count_after = COUNT_OUT_W'(init_sat);
				end else begin
					rsp.status = ST_TABLE_FULL;
				end
			end
			OP_WAIT: begin
				if (found) begin
					rsp.slot = SLOT_W'(match_idx);
					if (cnt == '0) begin
						rsp.status = ST_WOULD_BLOCK;
					end else begin
						wr.count_en     = 1'b1;
						wr_count        = cnt - 1'b1;
						rsp.status      = ST_OK;
						rsp.count_after = COUNT_OUT_W'(cnt - 1'b1);
					end
				end
			end
			OP_POST: begin
				if (found) begin
					rsp.slot = SLOT_W'(match_idx);
					rsp.wake = 1'b1;
					if (cnt == CNT_MAX) begin
						rsp.status      = ST_SATURATED;
						rsp.count_after = COUNT_OUT_W'(CNT_MAX);
					end else begin
						wr.count_en     = 1'b1;
						wr_count        = cnt + 1'b1;
						rsp.status      = ST_OK;
						rsp.count_after = COUNT_OUT_W'(cnt + 1'b1);
					end
				end
			end
			default: begin
				rsp.status = ST_NOT_FOUND;
			end
		endcase
	end

endmodule

[hw/rtl/keyed_counting_semaphore_table_core.sv]
// Top level of the keyed counting semaphore table: scan sequencer and output register.
//
// Requests arrive on req/req_valid/req_stall and carry an operation (open, wait,
// post), a 32-bit key and an initial count. Each request gives exactly one
// response on rsp/rsp_valid/rsp_stall with a status, the slot, the count after
// the operation and a wake flag for posts.
// A request is handled one at a time: req_stall stays high from the cycle after
// acceptance until the response has been taken. The sequencer reads one slot
// per cycle from the key and count memories and compares it against the key,
// remembering the lowest free slot on the way; the scan stops at the first
// match. After the scan the request passes through the execute state, which
// writes the table and registers the response, and then the response state.
// The next request can be taken in the cycle after the response is taken.
// The response is held in a register; while rsp_stall is high it stays stable
// and no new request is accepted.
// Reset marks every slot free and returns the sequencer to idle; no clearing
// pass is needed since key and count are used only from slots in use.
module keyed_counting_semaphore_table_core #(
	parameter int unsigned TABLE_SLOTS = kcst_pkg::TABLE_SLOTS_DEF,
	parameter int unsigned COUNT_WIDTH = kcst_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kcst_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output kcst_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);
	import kcst_pkg::*;

	localparam int unsigned IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned SCAN_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_SLOTS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	state_t state_q, state_d;

	req_t                   req_q;
	logic [SCAN_W-1:0]      scan_q;
	logic                   found_q;
	logic [IDX_W-1:0]       match_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_q;
	rsp_t                   rsp_q;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       rd_idx_s1;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [KEY_W-1:0]       rd_key_s1;
	logic [COUNT_WIDTH-1:0] rd_count_s1;
	logic                   rd_used_s1;
	logic                   key_hit;
	logic                   free_hit;
	logic                   scan_last;
	logic                   accept;

	rsp_t                   alu_rsp;
	tbl_wr_t                alu_wr;
	tbl_wr_t                tbl_wr;
	logic [IDX_W-1:0]       wr_idx;
	logic [COUNT_WIDTH-1:0] wr_count;

	assign accept  = req_valid && !req_stall;
	assign rd_en   = (state_q == S_SCAN) && (scan_q != SCAN_END);
	assign rd_addr = scan_q[IDX_W-1:0];

	// The one key comparator, applied to each slot as its read data returns.
	assign key_hit   = rd_valid_s1 && rd_used_s1 && (rd_key_s1 == req_q.sem_key);
	assign free_hit  = rd_valid_s1 && !rd_used_s1 && !free_found_q;
	assign scan_last = rd_valid_s1 && (rd_idx_s1 == LAST_IDX);

	assign tbl_wr.new_en   = alu_wr.new_en && (state_q == S_EXEC);
	assign tbl_wr.count_en = alu_wr.count_en && (state_q == S_EXEC);

	kcst_table #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.COUNT_WIDTH(COUNT_WIDTH),
		.IDX_W(IDX_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_key_s1(rd_key_s1),
		.rd_count_s1(rd_count_s1),
		.rd_used_s1(rd_used_s1),
		.wr(tbl_wr),
		.wr_idx(wr_idx),
		.wr_key(req_q.sem_key),
		.wr_count(wr_count)
	);

	kcst_alu #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.IDX_W(IDX_W)
	) u_alu (
		.op(req_q.op),
		.found(found_q),
		.match_idx(match_q),
		.cnt(cnt_q),
		.free_found(free_found_q),
		.free_idx(free_q),
		.init_value(req_q.init_value),
		.rsp(alu_rsp),
		.wr(alu_wr),
		.wr_idx(wr_idx),
		.wr_count(wr_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (key_hit || scan_last) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (accept) begin
				scan_q       <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (rd_en) begin
					scan_q <= SCAN_W'(scan_q + 1'b1);
				end
				if (key_hit) begin
					found_q <= 1'b1;
				end
				if (free_hit) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (accept) begin
			req_q <= req;
		end
		if ((state_q == S_SCAN) && key_hit) begin
			match_q <= rd_idx_s1;
			cnt_q   <= rd_count_s1;
		end
		if ((state_q == S_SCAN) && free_hit) begin
			free_q <= rd_idx_s1;
		end
		if (state_q == S_EXEC) begin
			rsp_q <= alu_rsp;
		end
	end

	assign rsp = rsp_q;

endmodule

[hw/rtl/kcst_checker.sv]
// Port-level checks for the semaphore table core, bound to the top level.
module kcst_port_checks (
	input logic           clk,
	input logic           arst_n,
	input kcst_pkg::req_t req,
	input logic           req_valid,
	input logic           req_stall,
	input kcst_pkg::rsp_t rsp,
	input logic           rsp_valid,
	input logic           rsp_stall
);
	import kcst_pkg::*;

	// A stalled response keeps its value until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// After a request is accepted, the request side is closed and no response is yet valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall && !rsp_valid)
		else $error("block not busy after accepting a request");

	// While a response waits, the request side is closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request accepted while a response is pending");

	// A full table or unknown key reports no slot and no count.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_TABLE_FULL || rsp.status == ST_NOT_FOUND)
		|-> rsp.slot == '0 && rsp.count_after == '0 && !rsp.wake)
		else $error("failed lookup reports a slot or count");

	// Wake is raised only by a post that reached a slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.wake |-> rsp.status == ST_OK || rsp.status == ST_SATURATED)
		else $error("wake raised with a failing status");

endmodule

bind keyed_counting_semaphore_table_core kcst_port_checks u_kcst_port_checks (.*);
